/* hdl/tlgs_pkg.sv */
// Shared types and constants for the toroidal life generation step block.
// Holds the command codes, register indexes, item layout and the control and
// status bundles between the controller and the datapath. Depends on nothing.
package tlgs_pkg;

    // Grid size defaults and fixed field widths.
    localparam int DEFAULT_MAX_WIDTH  = 64;
    localparam int DEFAULT_MAX_HEIGHT = 64;
    localparam int CMD_W              = 2;
    localparam int COORD_W            = 6;
    localparam int SIZE_W             = 7;
    localparam int CFG_IDX_W          = 2;
    localparam int ITEM_W             = 2 * COORD_W + 1;
    localparam int IN_TDATA_W         = 16;
    localparam int OUT_TDATA_W        = 8;

    localparam logic [SIZE_W-1:0] RESET_GRID_WIDTH  = 7'd45;
    localparam logic [SIZE_W-1:0] RESET_GRID_HEIGHT = 7'd35;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

    // B3/S23 neighbour counts.
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_STEP  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    // Input payload as it sits in tdata, cell_x in the lowest bits.
    typedef struct packed {
        logic               cell_in;
        logic [COORD_W-1:0] cell_y;
        logic [COORD_W-1:0] cell_x;
    } item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic row_rst;
        logic row_inc;
        logic clear_row;
        logic rd_up;
        logic rd_dn;
        logic cap_up;
        logic cap_mid;
        logic cap_dn;
        logic wr_next;
        logic cell_op;
        logic swap;
        logic out_load;
    } ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic row_last;
        logic out_free;
    } stat_t;

endpackage

/* hdl/tlgs_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// Stands alone; used for both cell banks of the life grid.
module tlgs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/tlgs_ctrl.sv */
// Sequencer of the life grid block: clearing pass, cell access and the
// row-by-row generation step. Depends on tlgs_pkg.
module tlgs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  tlgs_pkg::cmd_t      in_cmd,
    output logic                in_ready,
    input  tlgs_pkg::stat_t     stat,
    output tlgs_pkg::ctrl_t     ctrl
);

    import tlgs_pkg::*;

    typedef enum logic [8:0] {
        ST_CLEAR  = 9'b000000001,
        ST_IDLE   = 9'b000000010,
        ST_CELL   = 9'b000000100,
        ST_RD_UP  = 9'b000001000,
        ST_RD_MID = 9'b000010000,
        ST_RD_DN  = 9'b000100000,
        ST_CAP_DN = 9'b001000000,
        ST_WR_ROW = 9'b010000000,
        ST_DONE   = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                ctrl.clear_row = 1'b1;
                ctrl.row_inc   = 1'b1;
                if (stat.row_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.load_item = 1'b1;
                    ctrl.row_rst   = 1'b1;
                    case (in_cmd)
                        CMD_WRITE: state_next = ST_CELL;
                        CMD_READ:  state_next = ST_CELL;
                        CMD_STEP:  state_next = ST_RD_UP;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_CELL:
            begin
                ctrl.cell_op = 1'b1;
                state_next   = ST_DONE;
            end
            ST_RD_UP:
            begin
                ctrl.rd_up = 1'b1;
                state_next = ST_RD_MID;
            end
            ST_RD_MID:
            begin
                ctrl.cap_up = 1'b1;
                state_next  = ST_RD_DN;
            end
            ST_RD_DN:
            begin
                ctrl.cap_mid = 1'b1;
                ctrl.rd_dn   = 1'b1;
                state_next   = ST_CAP_DN;
            end
            ST_CAP_DN:
            begin
                ctrl.cap_dn = 1'b1;
                state_next  = ST_WR_ROW;
            end
            ST_WR_ROW:
            begin
                ctrl.wr_next = 1'b1;
                ctrl.row_inc = 1'b1;
                if (stat.row_last)
                begin
                    ctrl.swap  = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_RD_UP;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

/* hdl/tlgs_datapath.sv */
// Datapath of the life grid block: the two row-wide cell banks, the row
// window registers, the B3/S23 row logic, configuration and output registers.
// Depends on tlgs_pkg and tlgs_ram.
module tlgs_datapath #(
    parameter int MAX_WIDTH  = tlgs_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = tlgs_pkg::DEFAULT_MAX_HEIGHT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tlgs_pkg::ctrl_t                   ctrl,
    output tlgs_pkg::stat_t                   stat,
    input  tlgs_pkg::cmd_t                    in_cmd,
    input  tlgs_pkg::item_t                   in_item,
    input  logic                              cfg_we,
    input  logic [tlgs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tlgs_pkg::SIZE_W-1:0]       cfg_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              out_cell,
    output tlgs_pkg::cmd_t                    out_kind
);

    import tlgs_pkg::*;

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int EWC = $clog2(MAX_WIDTH + 1);
    localparam int EHC = $clog2(MAX_HEIGHT + 1);
    localparam int EW  = (EWC > SIZE_W) ? EWC : SIZE_W;
    localparam int EH  = (EHC > SIZE_W) ? EHC : SIZE_W;

    // Configuration and effective grid size.
    logic [SIZE_W-1:0] grid_width_reg;
    logic [SIZE_W-1:0] grid_height_reg;
    logic [EW-1:0]     w_eff;
    logic [EH-1:0]     h_eff;
    logic [XW-1:0]     wm1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= RESET_GRID_WIDTH;
            grid_height_reg <= RESET_GRID_HEIGHT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                REG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign w_eff = (EW'(grid_width_reg) > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH)
                                                          : EW'(grid_width_reg);
    assign h_eff = (EH'(grid_height_reg) > EH'(MAX_HEIGHT)) ? EH'(MAX_HEIGHT)
                                                            : EH'(grid_height_reg);
    assign wm1   = XW'(w_eff - 1'b1);

    // Item registers and bank selection.
    cmd_t               item_cmd_reg;
    logic [COORD_W-1:0] item_x_reg;
    logic [COORD_W-1:0] item_y_reg;
    logic               item_val_reg;
    logic               in_area_reg;
    logic               in_area;
    logic               active_reg;
    logic [YW-1:0]      y_reg;

    assign in_area = (EW'(in_item.cell_x) < w_eff) && (EH'(in_item.cell_y) < h_eff);

    always_ff @(posedge clk)
    begin
        if (ctrl.load_item)
        begin
            item_cmd_reg <= in_cmd;
            item_x_reg   <= in_item.cell_x;
            item_y_reg   <= in_item.cell_y;
            item_val_reg <= in_item.cell_in;
            in_area_reg  <= in_area;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            y_reg      <= '0;
        end
        else
        begin
            if (ctrl.swap)
            begin
                active_reg <= ~active_reg;
            end
            if (ctrl.row_rst)
            begin
                y_reg <= '0;
            end
            else if (ctrl.row_inc)
            begin
                y_reg <= y_reg + 1'b1;
            end
        end
    end

    // Row addresses of the window, wrapped over the active height.
    logic [YW-1:0] up_addr;
    logic [YW-1:0] dn_addr;
    logic [YW-1:0] raddr;

    assign up_addr = (y_reg == '0) ? YW'(h_eff - 1'b1) : y_reg - 1'b1;
    assign dn_addr = (EH'(y_reg) == h_eff - 1'b1) ? '0 : y_reg + 1'b1;

    always_comb
    begin
        if (ctrl.load_item)
        begin
            raddr = YW'(in_item.cell_y);
        end
        else if (ctrl.rd_up)
        begin
            raddr = up_addr;
        end
        else if (ctrl.rd_dn)
        begin
            raddr = dn_addr;
        end
        else
        begin
            raddr = y_reg;
        end
    end

    // Banks.
    logic [MAX_WIDTH-1:0] rd_a;
    logic [MAX_WIDTH-1:0] rd_b;
    logic [MAX_WIDTH-1:0] src_row;
    logic [MAX_WIDTH-1:0] new_row;
    logic [MAX_WIDTH-1:0] cell_row;
    logic [MAX_WIDTH-1:0] wdata;
    logic [YW-1:0]        waddr;
    logic                 cell_we;
    logic                 we_a;
    logic                 we_b;
    logic [XW-1:0]        col_sel;

    assign src_row = active_reg ? rd_b : rd_a;
    assign col_sel = XW'(item_x_reg);
    assign cell_we = ctrl.cell_op && (item_cmd_reg == CMD_WRITE) && in_area_reg;

    always_comb
    begin
        cell_row          = src_row;
        cell_row[col_sel] = item_val_reg;
    end

    always_comb
    begin
        if (ctrl.clear_row)
        begin
            wdata = '0;
            waddr = y_reg;
        end
        else if (ctrl.wr_next)
        begin
            wdata = new_row;
            waddr = y_reg;
        end
        else
        begin
            wdata = cell_row;
            waddr = YW'(item_y_reg);
        end
    end

    // Clearing writes both banks; a step writes the inactive one; a cell
    // write goes to the active one.
    assign we_a = ctrl.clear_row || (ctrl.wr_next && active_reg) || (cell_we && !active_reg);
    assign we_b = ctrl.clear_row || (ctrl.wr_next && !active_reg) || (cell_we && active_reg);

    tlgs_ram #(
        .WIDTH (MAX_WIDTH),
        .DEPTH (MAX_HEIGHT)
    ) u_bank_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rd_a)
    );

    tlgs_ram #(
        .WIDTH (MAX_WIDTH),
        .DEPTH (MAX_HEIGHT)
    ) u_bank_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rd_b)
    );

    // Window rows.
    logic [MAX_WIDTH-1:0] up_reg;
    logic [MAX_WIDTH-1:0] mid_reg;
    logic [MAX_WIDTH-1:0] dn_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.cap_up)
        begin
            up_reg <= src_row;
        end
        if (ctrl.cap_mid)
        begin
            mid_reg <= src_row;
        end
        if (ctrl.cap_dn)
        begin
            dn_reg <= src_row;
        end
    end

    // Next generation of one row; columns wrap over the active width, and
    // cells outside the active area come out dead.
    always_comb
    begin
        logic [XW-1:0] li;
        logic [XW-1:0] ri;
        logic [3:0]    n;
        logic          self;
        logic          row_in_area;
        row_in_area = EH'(y_reg) < h_eff;
        new_row     = '0;
        for (int c = 0; c < MAX_WIDTH; c++)
        begin
            li = (c == 0) ? wm1 : XW'(c - 1);
            ri = ((c == MAX_WIDTH - 1) || (XW'(c) == wm1)) ? '0 : XW'(c + 1);
            self = mid_reg[c];
            n = 4'(up_reg[li]) + 4'(up_reg[c]) + 4'(up_reg[ri])
              + 4'(mid_reg[li]) + 4'(mid_reg[ri])
              + 4'(dn_reg[li]) + 4'(dn_reg[c]) + 4'(dn_reg[ri]);
            new_row[c] = ((n == BIRTH_COUNT) || ((n == SURVIVE_COUNT) && self))
                         && (EW'(c) < w_eff) && row_in_area;
        end
    end

    // Result and output register.
    logic res_reg;
    logic out_valid_reg;
    logic out_cell_reg;
    cmd_t out_kind_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load_item)
        begin
            res_reg <= 1'b0;
        end
        else if (ctrl.cell_op)
        begin
            res_reg <= (item_cmd_reg == CMD_READ) && in_area_reg && src_row[col_sel];
        end
        if (ctrl.out_load)
        begin
            out_cell_reg <= res_reg;
            out_kind_reg <= item_cmd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_cell      = out_cell_reg;
    assign out_kind      = out_kind_reg;
    assign stat.row_last = (y_reg == YW'(MAX_HEIGHT - 1));
    assign stat.out_free = !out_valid_reg || out_ready;

endmodule

/* hdl/toroidal_life_generation_step.sv */
// Top level of the toroidal Game of Life block (rule B3/S23).
// Joins the sequencer tlgs_ctrl and the datapath tlgs_datapath; uses tlgs_pkg.
//
// Usage. Requests arrive on the s_axis channel: tuser carries the command
// (write cell, read cell, advance one generation), tdata the cell address and
// the value to write. Every request gives exactly one response on m_axis:
// tdata bit 0 is the cell read (0 for any other command), tuser echoes the
// command. The grid size is set through the cfg channel, which always accepts;
// write it only while the block is idle.
// Operation. The grid is held as rows of MAX_WIDTH cells in two banks. A cell
// read or write costs one bank access. A step reads three rows and writes one
// per row through the single read port of each bank, over all MAX_HEIGHT rows.
// The unused command code skips the bank access.
// Reset. After rst_n is released a clearing pass writes every row of both banks
// dead; s_axis_tready stays low until it is over. Sizes return to 45 by 35 and
// bank a becomes active.
// Stalls. The response sits in an output register; while m_axis_tready is low
// the next request is still accepted and worked on, and only its own response
// waits for the register to be freed.
module toroidal_life_generation_step #(
    parameter int MAX_WIDTH  = tlgs_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = tlgs_pkg::DEFAULT_MAX_HEIGHT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Request channel.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata fields from bit 0: cell_x[5:0], cell_y[11:6], cell_in[12], zero fill.
    input  logic [tlgs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // tuser fields from bit 0: command[1:0].
    input  logic [tlgs_pkg::CMD_W-1:0]          s_axis_tuser,
    // Response channel.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata fields from bit 0: cell_out[0], zero fill.
    output logic [tlgs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // tuser fields from bit 0: done_kind[1:0].
    output logic [tlgs_pkg::CMD_W-1:0]          m_axis_tuser,
    // Configuration channel: index 0 grid_width, index 1 grid_height.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tlgs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tlgs_pkg::SIZE_W-1:0]         cfg_data
);

    import tlgs_pkg::*;

    ctrl_t ctrl;
    stat_t stat;
    cmd_t  in_cmd;
    item_t in_item;
    cmd_t  out_kind;
    logic  out_cell;

    assign in_cmd    = cmd_t'(s_axis_tuser);
    assign in_item   = item_t'(s_axis_tdata[ITEM_W-1:0]);
    assign cfg_ready = 1'b1;

    tlgs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_cmd   (in_cmd),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    tlgs_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .in_cmd    (in_cmd),
        .in_item   (in_item),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_cell  (out_cell),
        .out_kind  (out_kind)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - 1){1'b0}}, out_cell};
    assign m_axis_tuser = out_kind;

    // The clearing pass holds off requests right after reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !s_axis_tready)
        else $error("request accepted during the clearing pass");

    // One request at a time: an accepted request blocks the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second request accepted while one is in progress");

    // The banks swap only with the write of the last row of a step.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.swap |-> (ctrl.wr_next && stat.row_last))
        else $error("bank swap outside the end of a step");

    // A response is never loaded over one that has not been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.out_load |-> stat.out_free)
        else $error("response register overwritten");

endmodule
